/* src/aapr_pkg.sv */
`default_nettype none
package aapr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QW = 35;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int AXIS_LAT = 5 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int MATRIX_LAT = 5;

  typedef logic signed [QW-1:0] q30_t;

  localparam q30_t Q30_ONE = 35'sd1073741824;
  localparam q30_t Q30_PI = 35'sd3373259426;
  localparam q30_t Q30_HALFPI = 35'sd1686629713;
  localparam q30_t Q30_TWOPI = 35'sd6746518852;
  localparam q30_t CORDIC_GAIN = 35'sd652032874;
  localparam logic [63:0] TWOPI64 = 64'd6746518852;

  localparam logic [29:0] ATAN [CORDIC_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  function automatic int mod_steps(input int fb);
    int tw;
    tw = 51 - fb;
    return (tw > 33) ? tw - 32 : 1;
  endfunction

  function automatic int sincos_lat(input int fb);
    return 34 + mod_steps(fb);
  endfunction

  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return p[QW+29:30];
  endfunction

endpackage
`default_nettype wire

/* src/axis_angle_point_rotation.sv */
`default_nettype none
// 74 register stages from the accepting edge to the out_valid strobe
// throughput: one point per cycle; the 32-stage square root and the 31-stage
// divider of the axis path set the depth, the sine/cosine path is delayed to match
// busy stays low: the receiver cannot stall, so every cycle takes a beat
// reset (synchronous, active low) clears the valid bits only
module axis_angle_point_rotation #(
  parameter int FRAC_BITS = aapr_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  input  wire logic signed [19:0] in_angle,
  input  wire logic signed [31:0] in_axis_x,
  input  wire logic signed [31:0] in_axis_y,
  input  wire logic signed [31:0] in_axis_z,
  output logic                    out_valid,
  output logic signed [31:0]      out_rotated_x,
  output logic signed [31:0]      out_rotated_y,
  output logic signed [31:0]      out_rotated_z,
  output logic                    out_zero_axis
);

  localparam int QW = aapr_pkg::QW;
  localparam int SC_DLY = aapr_pkg::AXIS_LAT - aapr_pkg::sincos_lat(FRAC_BITS);

  logic in_valid;
  logic signed [31:0] axis_v [3];
  aapr_pkg::q30_t u_v [3];
  logic zero_v, uvalid_v;
  aapr_pkg::q30_t sin_v, cos_v, one_c_v;
  logic [3*QW-1:0] sc_d;
  logic [95:0] p_d;
  logic signed [31:0] p_v [3];
  logic signed [31:0] rot_v [3];

  assign busy = 1'b0;
  assign in_valid = start && !busy;

  assign axis_v[0] = in_axis_x;
  assign axis_v[1] = in_axis_y;
  assign axis_v[2] = in_axis_z;

  aapr_axis u_axis (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .axis_i  (axis_v),
    .u_o     (u_v),
    .zero_o  (zero_v),
    .valid_o (uvalid_v)
  );

  aapr_sincos #(.FRAC_BITS(FRAC_BITS)) u_sincos (
    .clk     (clk),
    .angle_i (in_angle),
    .sin_o   (sin_v),
    .cos_o   (cos_v),
    .one_c_o (one_c_v)
  );

  aapr_delay #(.W(3*QW), .D(SC_DLY)) u_sc_dly (
    .clk (clk),
    .d_i ({sin_v, cos_v, one_c_v}),
    .q_o (sc_d)
  );

  aapr_delay #(.W(96), .D(aapr_pkg::AXIS_LAT)) u_pt_dly (
    .clk (clk),
    .d_i ({in_point_x, in_point_y, in_point_z}),
    .q_o (p_d)
  );

  assign p_v[0] = p_d[95:64];
  assign p_v[1] = p_d[63:32];
  assign p_v[2] = p_d[31:0];

  aapr_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (uvalid_v),
    .zero_i  (zero_v),
    .u_i     (u_v),
    .sin_i   (sc_d[3*QW-1:2*QW]),
    .cos_i   (sc_d[2*QW-1:QW]),
    .one_c_i (sc_d[QW-1:0]),
    .p_i     (p_v),
    .rot_o   (rot_v),
    .zero_o  (out_zero_axis),
    .valid_o (out_valid)
  );

  assign out_rotated_x = rot_v[0];
  assign out_rotated_y = rot_v[1];
  assign out_rotated_z = rot_v[2];

endmodule
`default_nettype wire

/* src/aapr_delay.sv */
`default_nettype none
module aapr_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] sh_r [0:D-1];

  always_ff @(posedge clk) begin
    sh_r[0] <= d_i;
  end

  for (genvar i = 1; i < D; i++) begin : g_tap
    always_ff @(posedge clk) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  assign q_o = sh_r[D-1];

endmodule
`default_nettype wire

/* src/aapr_sincos.sv */
`default_nettype none
module aapr_sincos #(
  parameter int FRAC_BITS = aapr_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic signed [19:0] angle_i,
  output aapr_pkg::q30_t          sin_o,
  output aapr_pkg::q30_t          cos_o,
  output aapr_pkg::q30_t          one_c_o
);

  localparam int TW = 51 - FRAC_BITS;
  localparam int MW = ((TW > 33) ? TW : 33) + 1;
  localparam int MS = aapr_pkg::mod_steps(FRAC_BITS);
  localparam int SH = 30 - FRAC_BITS;
  localparam int CS = aapr_pkg::CORDIC_STEPS;

  logic signed [20:0] ang_ext;
  logic [19:0] ang_abs;
  logic [MW-1:0] rem_r [0:MS];
  logic neg_r [0:MS];

  assign ang_ext = 21'(angle_i);
  assign ang_abs = ang_ext[20] ? 20'(-ang_ext) : 20'(ang_ext);

  // angle magnitude in q30; the flag marks a positive angle, whose result is negated
  always_ff @(posedge clk) begin
    rem_r[0] <= MW'(ang_abs) << SH;
    neg_r[0] <= !ang_ext[20] && (ang_ext != '0);
  end

  for (genvar j = 0; j < MS; j++) begin : g_mod
    localparam int K = MS - 1 - j;
    localparam logic [MW-1:0] STEP = MW'(aapr_pkg::TWOPI64 << K);
    always_ff @(posedge clk) begin
      rem_r[j+1] <= (rem_r[j] >= STEP) ? rem_r[j] - STEP : rem_r[j];
      neg_r[j+1] <= neg_r[j];
    end
  end

  aapr_pkg::q30_t zr_c, zw_c, zw_r, zf_c;
  logic flip_c;

  always_comb begin
    zr_c = aapr_pkg::q30_t'(rem_r[MS]);
    zw_c = neg_r[MS] ? -zr_c : zr_c;
    if (zw_c > aapr_pkg::Q30_PI) begin
      zw_c = zw_c - aapr_pkg::Q30_TWOPI;
    end else if (zw_c < -aapr_pkg::Q30_PI) begin
      zw_c = zw_c + aapr_pkg::Q30_TWOPI;
    end
  end

  always_ff @(posedge clk) begin
    zw_r <= zw_c;
  end

  // fold into the right half plane
  always_comb begin
    zf_c = zw_r;
    flip_c = 1'b0;
    if (zw_r > aapr_pkg::Q30_HALFPI) begin
      zf_c = zw_r - aapr_pkg::Q30_PI;
      flip_c = 1'b1;
    end else if (zw_r < -aapr_pkg::Q30_HALFPI) begin
      zf_c = zw_r + aapr_pkg::Q30_PI;
      flip_c = 1'b1;
    end
  end

  aapr_pkg::q30_t cx_r [0:CS];
  aapr_pkg::q30_t cy_r [0:CS];
  aapr_pkg::q30_t cz_r [0:CS];
  logic cf_r [0:CS];

  always_ff @(posedge clk) begin
    cx_r[0] <= aapr_pkg::CORDIC_GAIN;
    cy_r[0] <= '0;
    cz_r[0] <= zf_c;
    cf_r[0] <= flip_c;
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam aapr_pkg::q30_t AT = aapr_pkg::q30_t'(aapr_pkg::ATAN[i]);
    always_ff @(posedge clk) begin
      if (cz_r[i] >= 0) begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - AT;
      end else begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + AT;
      end
      cf_r[i+1] <= cf_r[i];
    end
  end

  aapr_pkg::q30_t c_c;
  assign c_c = cf_r[CS] ? -cx_r[CS] : cx_r[CS];

  always_ff @(posedge clk) begin
    sin_o <= cf_r[CS] ? -cy_r[CS] : cy_r[CS];
    cos_o <= c_c;
    one_c_o <= aapr_pkg::Q30_ONE - c_c;
  end

endmodule
`default_nettype wire

/* src/aapr_axis.sv */
`default_nettype none
module aapr_axis (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] axis_i [3],
  output aapr_pkg::q30_t          u_o [3],
  output logic                    zero_o,
  output logic                    valid_o
);

  localparam int SS = aapr_pkg::SQRT_STEPS;
  localparam int DS = aapr_pkg::DIV_STEPS;

  // magnitudes and largest one
  logic [31:0] mag_c [3];
  logic [31:0] mx_c;
  logic [31:0] mag1_r [3];
  logic sgn1_r [3];
  logic [31:0] mx1_r;
  logic v1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = axis_i[i][31] ? 32'(-axis_i[i]) : 32'(axis_i[i]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag1_r[i] <= mag_c[i];
      sgn1_r[i] <= axis_i[i][31];
    end
    mx1_r <= mx_c;
  end

  // leading one
  logic [4:0] pos_c;
  logic [4:0] pos2_r;
  logic [31:0] mag2_r [3];
  logic sgn2_r [3];
  logic zero2_r, v2_r;

  always_comb begin
    pos_c = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx1_r[b]) pos_c = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    pos2_r <= pos_c;
    mag2_r <= mag1_r;
    sgn2_r <= sgn1_r;
    zero2_r <= (mx1_r == '0);
  end

  // shift so the largest lies in [2^29, 2^30)
  logic [29:0] nm_c [3];
  logic [29:0] nm3_r [3];
  logic sgn3_r [3];
  logic zero3_r, v3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2_r >= 5'd30) begin
        nm_c[i] = 30'(mag2_r[i] >> (pos2_r - 5'd29));
      end else begin
        nm_c[i] = 30'(mag2_r[i] << (5'd29 - pos2_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    nm3_r <= nm_c;
    sgn3_r <= sgn2_r;
    zero3_r <= zero2_r;
  end

  // squares
  logic [59:0] sq4_r [3];
  logic [29:0] nm4_r [3];
  logic sgn4_r [3];
  logic zero4_r, v4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq4_r[i] <= nm3_r[i] * nm3_r[i];
    end
    nm4_r <= nm3_r;
    sgn4_r <= sgn3_r;
    zero4_r <= zero3_r;
  end

  // bit-serial square root, one result bit per stage
  logic [63:0] sv_r [0:SS];
  logic [63:0] rt_r [0:SS];
  logic [29:0] nms_r [0:SS][3];
  logic sgns_r [0:SS][3];
  logic zs_r [0:SS];
  logic vs_r [0:SS];

  always_ff @(posedge clk) begin
    sv_r[0] <= 64'(sq4_r[0]) + 64'(sq4_r[1]) + 64'(sq4_r[2]);
    rt_r[0] <= '0;
    nms_r[0] <= nm4_r;
    sgns_r[0] <= sgn4_r;
    zs_r[0] <= zero4_r;
  end

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = rt_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (sv_r[k] >= trial) begin
        sv_r[k+1] <= sv_r[k] - trial;
        rt_r[k+1] <= (rt_r[k] >> 1) + BIT;
      end else begin
        sv_r[k+1] <= sv_r[k];
        rt_r[k+1] <= rt_r[k] >> 1;
      end
      nms_r[k+1] <= nms_r[k];
      sgns_r[k+1] <= sgns_r[k];
      zs_r[k+1] <= zs_r[k];
    end
  end

  // restoring division, one quotient bit per stage
  logic [61:0] rm_r [0:DS][3];
  logic [30:0] qt_r [0:DS][3];
  logic [30:0] dr_r [0:DS];
  logic sgnd_r [0:DS][3];
  logic zd_r [0:DS];
  logic vd_r [0:DS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rm_r[0][i] = 62'(nms_r[SS][i]) << 30;
      qt_r[0][i] = '0;
    end
    dr_r[0] = rt_r[SS][30:0];
    sgnd_r[0] = sgns_r[SS];
    zd_r[0] = zs_r[SS];
    vd_r[0] = vs_r[SS];
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int K = DS - 1 - j;
    logic [61:0] sub;
    assign sub = 62'(dr_r[j]) << K;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (rm_r[j][i] >= sub) begin
          rm_r[j+1][i] <= rm_r[j][i] - sub;
          qt_r[j+1][i] <= qt_r[j][i] | (31'd1 << K);
        end else begin
          rm_r[j+1][i] <= rm_r[j][i];
          qt_r[j+1][i] <= qt_r[j][i];
        end
      end
      dr_r[j+1] <= dr_r[j];
      sgnd_r[j+1] <= sgnd_r[j];
      zd_r[j+1] <= zd_r[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u_o[i] <= sgnd_r[DS][i] ? -aapr_pkg::q30_t'(qt_r[DS][i])
                              : aapr_pkg::q30_t'(qt_r[DS][i]);
    end
    zero_o <= zd_r[DS];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vs_r[0] <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vs_r[0] <= v4_r;
    end
  end

  for (genvar k = 0; k < SS; k++) begin : g_vs
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else begin
        vs_r[k+1] <= vs_r[k];
      end
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_vd
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else begin
        vd_r[j+1] <= vd_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= vd_r[DS];
    end
  end

endmodule
`default_nettype wire

/* src/aapr_matrix.sv */
`default_nettype none
module aapr_matrix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  input  wire logic               zero_i,
  input  wire aapr_pkg::q30_t     u_i [3],
  input  wire aapr_pkg::q30_t     sin_i,
  input  wire aapr_pkg::q30_t     cos_i,
  input  wire aapr_pkg::q30_t     one_c_i,
  input  wire logic signed [31:0] p_i [3],
  output logic signed [31:0]      rot_o [3],
  output logic                    zero_o,
  output logic                    valid_o
);

  function automatic logic signed [31:0] clamp1(input aapr_pkg::q30_t v);
    if (v > aapr_pkg::Q30_ONE) return 32'sd1073741824;
    if (v < -aapr_pkg::Q30_ONE) return -32'sd1073741824;
    return 32'(v);
  endfunction

  // axis products
  aapr_pkg::q30_t xx_r, yy_r, zz_r, xy_r, yz_r, zx_r, xs_r, ys_r, zs_r, c1_r, oc1_r;
  logic signed [31:0] p1_r [3];
  logic z1_r, v1_r;

  always_ff @(posedge clk) begin
    xx_r <= aapr_pkg::mul30(u_i[0], u_i[0]);
    yy_r <= aapr_pkg::mul30(u_i[1], u_i[1]);
    zz_r <= aapr_pkg::mul30(u_i[2], u_i[2]);
    xy_r <= aapr_pkg::mul30(u_i[0], u_i[1]);
    yz_r <= aapr_pkg::mul30(u_i[1], u_i[2]);
    zx_r <= aapr_pkg::mul30(u_i[2], u_i[0]);
    xs_r <= aapr_pkg::mul30(u_i[0], sin_i);
    ys_r <= aapr_pkg::mul30(u_i[1], sin_i);
    zs_r <= aapr_pkg::mul30(u_i[2], sin_i);
    c1_r <= cos_i;
    oc1_r <= one_c_i;
    p1_r <= p_i;
    z1_r <= zero_i;
  end

  // scaled by one minus cosine
  aapr_pkg::q30_t oxx_r, oyy_r, ozz_r, oxy_r, oyz_r, ozx_r, xs2_r, ys2_r, zs2_r, c2_r;
  logic signed [31:0] p2_r [3];
  logic z2_r, v2_r;

  always_ff @(posedge clk) begin
    oxx_r <= aapr_pkg::mul30(oc1_r, xx_r);
    oyy_r <= aapr_pkg::mul30(oc1_r, yy_r);
    ozz_r <= aapr_pkg::mul30(oc1_r, zz_r);
    oxy_r <= aapr_pkg::mul30(oc1_r, xy_r);
    oyz_r <= aapr_pkg::mul30(oc1_r, yz_r);
    ozx_r <= aapr_pkg::mul30(oc1_r, zx_r);
    xs2_r <= xs_r;
    ys2_r <= ys_r;
    zs2_r <= zs_r;
    c2_r <= c1_r;
    p2_r <= p1_r;
    z2_r <= z1_r;
  end

  // matrix entries, row major
  logic signed [31:0] m_r [9];
  logic signed [31:0] p3_r [3];
  logic z3_r, v3_r;

  always_ff @(posedge clk) begin
    m_r[0] <= clamp1(oxx_r + c2_r);
    m_r[1] <= clamp1(oxy_r - zs2_r);
    m_r[2] <= clamp1(ozx_r + ys2_r);
    m_r[3] <= clamp1(oxy_r + zs2_r);
    m_r[4] <= clamp1(oyy_r + c2_r);
    m_r[5] <= clamp1(oyz_r - xs2_r);
    m_r[6] <= clamp1(ozx_r - ys2_r);
    m_r[7] <= clamp1(oyz_r + xs2_r);
    m_r[8] <= clamp1(ozz_r + c2_r);
    p3_r <= p2_r;
    z3_r <= z2_r;
  end

  // entry times coordinate
  logic signed [63:0] pr_r [9];
  logic signed [31:0] p4_r [3];
  logic z4_r, v4_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pr_r[3*r+k] <= m_r[3*r+k] * p3_r[k];
      end
    end
    p4_r <= p3_r;
    z4_r <= z3_r;
  end

  // row sums, round and saturate; a zero axis passes the point through
  logic signed [65:0] acc_c [3];
  logic signed [35:0] sh_c [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_c[r] = 66'(pr_r[3*r]) + 66'(pr_r[3*r+1]) + 66'(pr_r[3*r+2])
                 + 66'sd536870912;
      sh_c[r] = 36'(acc_c[r] >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      if (z4_r) begin
        rot_o[r] <= p4_r[r];
      end else if (sh_c[r] > 36'sd2147483647) begin
        rot_o[r] <= 32'sh7fffffff;
      end else if (sh_c[r] < -36'sd2147483648) begin
        rot_o[r] <= 32'sh80000000;
      end else begin
        rot_o[r] <= 32'(sh_c[r]);
      end
    end
    zero_o <= z4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      valid_o <= v4_r;
    end
  end

endmodule
`default_nettype wire
